>>> design/tese_pkg.sv
package tese_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;
  localparam int WARN_COL    = 72;

  localparam logic [6:0] ADDR_BIAS = 7'h1f;
  localparam logic [6:0] CH_MASK   = 7'h7f;
  localparam logic [6:0] CH_ESC    = 7'h1b;
  localparam logic [6:0] CH_SPACE  = 7'h20;
  localparam logic [6:0] CH_BEL    = 7'h07;
  localparam logic [6:0] CH_BS     = 7'h08;
  localparam logic [6:0] CH_HT     = 7'h09;
  localparam logic [6:0] CH_LF     = 7'h0a;
  localparam logic [6:0] CH_CR     = 7'h0d;

  localparam logic [6:0] KEY_UP        = 7'h41;  // A
  localparam logic [6:0] KEY_DOWN      = 7'h42;  // B
  localparam logic [6:0] KEY_RIGHT     = 7'h43;  // C
  localparam logic [6:0] KEY_LEFT      = 7'h44;  // D
  localparam logic [6:0] KEY_CLEAR     = 7'h45;  // E
  localparam logic [6:0] KEY_ADDR_F    = 7'h46;  // F
  localparam logic [6:0] KEY_SEND_CELL = 7'h47;  // G
  localparam logic [6:0] KEY_HOME      = 7'h48;  // H
  localparam logic [6:0] KEY_ERASE_PG  = 7'h4a;  // J
  localparam logic [6:0] KEY_ERASE_LN  = 7'h4b;  // K
  localparam logic [6:0] KEY_INS_LINE  = 7'h4c;  // L
  localparam logic [6:0] KEY_DEL_LINE  = 7'h4d;  // M
  localparam logic [6:0] KEY_INS_ON    = 7'h51;  // Q
  localparam logic [6:0] KEY_DEL_CHAR  = 7'h52;  // R
  localparam logic [6:0] KEY_ADDR_Y    = 7'h59;  // Y
  localparam logic [6:0] KEY_INS_OFF   = 7'h40;  // @
  localparam logic [6:0] KEY_REPORT    = 7'h5c;  // backslash
  localparam logic [6:0] KEY_ALARM     = 7'h33;  // 3

  localparam logic       OP_HOST = 1'b0;
  localparam logic       OP_READ = 1'b1;

  localparam logic [1:0] KIND_HOST  = 2'd0;
  localparam logic [1:0] KIND_ALARM = 2'd1;
  localparam logic [1:0] KIND_CELL  = 2'd2;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_LINE,
    ESC_COLUMN
  } esc_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_CELL_RD,
    ST_CELL_OUT,
    ST_REPORT
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_MOVE,
    ACT_CELL,
    ACT_REPORT
  } act_t;

endpackage

>>> design/terminal_escape_screen_engine.sv
// A cell read inside the screen or ESC G passes through EXEC and CELL_RD and gives its
// result in CELL_OUT; a read outside the screen strobes a space in EXEC. A control code,
// cursor move or alarm ends in EXEC unless it edits the screen; ESC \ sends 4 bytes.
// Screen edits walk the single-port-pair store, one read and one write per cell, with
// busy high until done; reset starts a clearing pass of the whole screen, busy high.
// The receiver cannot stall: each result is on the ports for one cycle with strobe.
module terminal_escape_screen_engine import tese_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  input  logic [4:0] read_row,
  input  logic [6:0] read_column,
  output logic       strobe,
  output logic [1:0] kind,
  output logic [6:0] value,
  output logic       last
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int W     = AW + 1;
  localparam logic [W-1:0] CELLS_W = W'(CELLS);
  localparam logic [W-1:0] COL_W   = W'(COLUMNS);
  localparam logic [W-1:0] LAST_W  = W'(CELLS - 1);
  localparam logic [W-1:0] ONE_W   = W'(1);
  localparam logic [7:0]   COL_MAX = 8'(COLUMNS - 1);
  localparam logic [4:0]   ROW_MAX = 5'(ROWS - 1);

  state_t     state, state_next;
  esc_phase_t esc;
  logic       in_op;
  logic [6:0] in_byte;
  logic [4:0] in_rrow;
  logic [6:0] in_rcol;
  logic [4:0] cur_row, pend_row;
  logic [6:0] cur_col;
  logic       ins_mode;

  logic [W-1:0] mv_dst, mv_lo, mv_hi, mv_gap;
  logic         mv_asc, src_ok;
  logic [6:0]   mv_fill;
  logic [AW-1:0] cell_addr;
  logic [1:0]   cell_kind;
  logic [1:0]   rep_cnt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [6:0]    mem_wdata, mem_rdata;

  // Decode results for the item held in the input registers.
  act_t         d_act;
  logic         d_alarm, d_space;
  esc_phase_t   d_esc;
  logic [4:0]   d_row, d_pend;
  logic [6:0]   d_col;
  logic         d_ins;
  logic [W-1:0] d_lo, d_hi, d_gap;
  logic         d_asc;
  logic [6:0]   d_fill;
  logic [AW-1:0] d_cell;
  logic [1:0]   d_kind;

  logic [W-1:0] row_base, cur_idx, row_end, rd_base;
  logic [7:0]   tab_col;
  logic [W-1:0] src_sum, src_dif, lo_gap;
  logic         src_ok_next, mv_done;

  assign row_base = W'(32'(cur_row) * COLUMNS);
  assign cur_idx  = row_base + W'(cur_col);
  assign row_end  = row_base + COL_W - ONE_W;
  assign rd_base  = W'(32'(in_rrow) * COLUMNS) + W'(in_rcol);
  assign tab_col  = {1'b0, cur_col[6:3], 3'b000} + 8'd8;

  always_comb begin
    d_act   = ACT_NONE;
    d_alarm = 1'b0;
    d_space = 1'b0;
    d_esc   = esc;
    d_row   = cur_row;
    d_col   = cur_col;
    d_pend  = pend_row;
    d_ins   = ins_mode;
    d_lo    = cur_idx;
    d_hi    = cur_idx;
    d_gap   = ONE_W;
    d_asc   = 1'b1;
    d_fill  = CH_SPACE;
    d_cell  = cur_idx[AW-1:0];
    d_kind  = KIND_HOST;
    if (in_op == OP_READ) begin
      if (32'(in_rrow) < ROWS && 32'(in_rcol) < COLUMNS) begin
        d_act  = ACT_CELL;
        d_cell = rd_base[AW-1:0];
        d_kind = KIND_CELL;
      end else begin
        d_space = 1'b1;
      end
    end else begin
      case (esc)
        ESC_SEEN: begin
          d_esc = ESC_IDLE;
          case (in_byte)
            KEY_UP:   d_row = (cur_row == 5'd0) ? ROW_MAX : cur_row - 5'd1;
            KEY_DOWN: d_row = (cur_row == ROW_MAX) ? 5'd0 : cur_row + 5'd1;
            KEY_RIGHT: begin
              if (8'(cur_col) < COL_MAX) begin
                d_col   = cur_col + 7'd1;
                d_alarm = (32'(cur_col) + 1 == WARN_COL);
              end else begin
                d_col = 7'd0;
                d_row = (cur_row == ROW_MAX) ? 5'd0 : cur_row + 5'd1;
              end
            end
            KEY_LEFT: begin
              if (cur_col != 7'd0) begin
                d_col = cur_col - 7'd1;
              end else begin
                d_col = COL_MAX[6:0];
                d_row = (cur_row == 5'd0) ? ROW_MAX : cur_row - 5'd1;
              end
            end
            KEY_HOME: begin
              d_row = 5'd0;
              d_col = 7'd0;
            end
            KEY_CLEAR: begin
              d_row = 5'd0;
              d_col = 7'd0;
              d_act = ACT_MOVE;
              d_lo  = '0;
              d_hi  = LAST_W;
              d_gap = CELLS_W;
            end
            KEY_ERASE_LN: begin
              d_act = ACT_MOVE;
              d_hi  = row_end;
              d_gap = CELLS_W;
            end
            KEY_ERASE_PG: begin
              d_act = ACT_MOVE;
              d_hi  = LAST_W;
              d_gap = CELLS_W;
            end
            KEY_INS_LINE: begin
              d_col = 7'd0;
              d_act = ACT_MOVE;
              d_lo  = row_base;
              d_hi  = LAST_W;
              d_gap = COL_W;
              d_asc = 1'b0;
            end
            KEY_DEL_LINE: begin
              d_act = ACT_MOVE;
              d_lo  = row_base;
              d_hi  = LAST_W;
              d_gap = COL_W;
            end
            KEY_DEL_CHAR: begin
              d_act = ACT_MOVE;
              d_hi  = row_end;
            end
            KEY_INS_ON:    d_ins = 1'b1;
            KEY_INS_OFF:   d_ins = 1'b0;
            KEY_ADDR_F:    d_esc = ESC_LINE;
            KEY_ADDR_Y:    d_esc = ESC_LINE;
            KEY_SEND_CELL: d_act = ACT_CELL;
            KEY_REPORT:    d_act = ACT_REPORT;
            KEY_ALARM:     d_alarm = 1'b1;
            default: ;
          endcase
        end
        ESC_LINE: begin
          if (in_byte <= ADDR_BIAS || 32'(in_byte) > ROWS + 32'(ADDR_BIAS)) begin
            d_esc = ESC_IDLE;
          end else begin
            d_pend = 5'(in_byte - CH_SPACE);
            d_esc  = ESC_COLUMN;
          end
        end
        ESC_COLUMN: begin
          d_esc = ESC_IDLE;
          if (in_byte > ADDR_BIAS && 32'(in_byte) <= COLUMNS + 32'(ADDR_BIAS)) begin
            d_row = pend_row;
            d_col = in_byte - CH_SPACE;
          end
        end
        default: begin
          if (in_byte >= CH_SPACE && in_byte != CH_MASK) begin
            // The write of the new character is the fill at the low end of a
            // downward shift; outside insert mode that shift covers one cell.
            d_act  = ACT_MOVE;
            d_asc  = 1'b0;
            d_fill = in_byte;
            d_hi   = ins_mode ? row_end : cur_idx;
            if (8'(cur_col) < COL_MAX) begin
              d_col   = cur_col + 7'd1;
              d_alarm = (32'(cur_col) + 1 == WARN_COL);
            end else begin
              d_col = 7'd0;
              d_row = (cur_row == ROW_MAX) ? 5'd0 : cur_row + 5'd1;
            end
          end else begin
            case (in_byte)
              CH_BS: begin
                if (cur_col != 7'd0) begin
                  d_col = cur_col - 7'd1;
                end else begin
                  d_col = COL_MAX[6:0];
                  d_row = (cur_row == 5'd0) ? ROW_MAX : cur_row - 5'd1;
                end
              end
              CH_HT: d_col = (tab_col > COL_MAX) ? COL_MAX[6:0] : tab_col[6:0];
              CH_LF: begin
                if (cur_row != ROW_MAX) begin
                  d_row = cur_row + 5'd1;
                end else begin
                  d_act = ACT_MOVE;
                  d_lo  = '0;
                  d_hi  = LAST_W;
                  d_gap = COL_W;
                end
              end
              CH_CR:  d_col = 7'd0;
              CH_BEL: d_alarm = 1'b1;
              CH_ESC: d_esc = ESC_SEEN;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // Block move engine: each cell is read in MOVE_RD and written in MOVE_WR, so a
  // source is never read after its own overwrite in either direction.
  assign src_sum     = mv_dst + mv_gap;
  assign src_dif     = mv_dst - mv_gap;
  assign lo_gap      = mv_lo + mv_gap;
  assign src_ok_next = mv_asc ? (src_sum <= mv_hi) : (mv_dst >= lo_gap);
  assign mv_done     = mv_asc ? (mv_dst == mv_hi) : (mv_dst == mv_lo);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_EXEC;
      ST_EXEC: begin
        case (d_act)
          ACT_MOVE:   state_next = ST_MOVE_RD;
          ACT_CELL:   state_next = ST_CELL_RD;
          ACT_REPORT: state_next = ST_REPORT;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_MOVE_RD:  state_next = ST_MOVE_WR;
      ST_MOVE_WR:  state_next = mv_done ? ST_IDLE : ST_MOVE_RD;
      ST_CELL_RD:  state_next = ST_CELL_OUT;
      ST_CELL_OUT: state_next = ST_IDLE;
      ST_REPORT:   if (rep_cnt == 2'd3) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    strobe    = 1'b0;
    kind      = KIND_HOST;
    value     = 7'd0;
    last      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = mv_dst[AW-1:0];
    mem_wdata = src_ok ? mem_rdata : mv_fill;
    mem_raddr = mv_asc ? src_sum[AW-1:0] : src_dif[AW-1:0];
    case (state)
      ST_EXEC: begin
        strobe = d_alarm | d_space;
        kind   = d_space ? KIND_CELL : KIND_ALARM;
        value  = d_space ? CH_SPACE : 7'd0;
      end
      ST_MOVE_WR:  mem_we = 1'b1;
      ST_CELL_RD:  mem_raddr = cell_addr;
      ST_CELL_OUT: begin
        strobe = 1'b1;
        kind   = cell_kind;
        value  = mem_rdata;
      end
      ST_REPORT: begin
        strobe = 1'b1;
        last   = (rep_cnt == 2'd3);
        case (rep_cnt)
          2'd0:    value = CH_ESC;
          2'd1:    value = KEY_ADDR_F;
          2'd2:    value = CH_SPACE + 7'(cur_row);
          default: value = CH_SPACE + cur_col;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_MOVE_RD;
      esc      <= ESC_IDLE;
      cur_row  <= 5'd0;
      cur_col  <= 7'd0;
      pend_row <= 5'd0;
      ins_mode <= 1'b0;
      rep_cnt  <= 2'd0;
      mv_dst   <= '0;
      mv_lo    <= '0;
      mv_hi    <= LAST_W;
      mv_gap   <= CELLS_W;
      mv_asc   <= 1'b1;
      mv_fill  <= CH_SPACE;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (start) begin
            in_op   <= operation;
            in_byte <= rx_byte[6:0];
            in_rrow <= read_row;
            in_rcol <= read_column;
          end
        end
        ST_EXEC: begin
          esc       <= d_esc;
          cur_row   <= d_row;
          cur_col   <= d_col;
          pend_row  <= d_pend;
          ins_mode  <= d_ins;
          mv_lo     <= d_lo;
          mv_hi     <= d_hi;
          mv_gap    <= d_gap;
          mv_asc    <= d_asc;
          mv_fill   <= d_fill;
          mv_dst    <= d_asc ? d_lo : d_hi;
          cell_addr <= d_cell;
          cell_kind <= d_kind;
          rep_cnt   <= 2'd0;
        end
        ST_MOVE_RD: src_ok <= src_ok_next;
        ST_MOVE_WR: mv_dst <= mv_asc ? mv_dst + ONE_W : mv_dst - ONE_W;
        ST_REPORT:  rep_cnt <= rep_cnt + 2'd1;
        default: ;
      endcase
    end
  end

  tese_screen_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  a_strobe_state: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (state == ST_EXEC || state == ST_CELL_OUT || state == ST_REPORT))
    else $error("result strobe outside a result state");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> $past(state) == ST_MOVE_RD)
    else $error("screen write without a preceding read");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS))
    else $error("cursor outside the screen");

  a_report_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && rep_cnt != 2'd3) |=> (state == ST_REPORT && strobe))
    else $error("cursor report cut short");

  a_move_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE_WR) |-> (mv_dst >= mv_lo && mv_dst <= mv_hi && mv_hi < CELLS_W))
    else $error("screen walk outside its range");

endmodule

>>> design/tese_screen_ram.sv
module tese_screen_ram import tese_pkg::*; #(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
  parameter int AW    = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
